@@ sv/sadr_pkg.sv @@
// Shared types, constants and helpers for the stick axis deadzone rescaler.
package sadr_pkg;

    localparam int CFG_W             = 12;
    localparam int IN_W              = 16;
    localparam int NORM_W            = 16;
    localparam int RAW_W             = 12;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int DIV_STEPS         = 2;
    localparam int LANE_Q            = 0;
    localparam int LANE_R            = 1;

    localparam logic [CFG_W-1:0] AXIS_MAXIMUM_RST    = 12'd4095;
    localparam logic [CFG_W-1:0] AXIS_CENTER_RST     = 12'd2048;
    localparam logic [CFG_W-1:0] DEAD_BAND_RST       = 12'd160;
    localparam logic [CFG_W-1:0] FULL_SCALE_SPAN_RST = 12'd1600;

    typedef enum logic [1:0] {
        CFG_AXIS_MAXIMUM    = 2'd0,
        CFG_AXIS_CENTER     = 2'd1,
        CFG_DEAD_BAND       = 2'd2,
        CFG_FULL_SCALE_SPAN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_cfg_idx          index;
        logic [CFG_W-1:0]  value;
    } t_cfg_wr;

    typedef struct packed {
        logic [IN_W-1:0] raw_sample;
    } t_in;

    typedef struct packed {
        logic signed [NORM_W-1:0] normalized_q14;
        logic [RAW_W-1:0]         rescaled_raw;
        logic                     inside_dead_band;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] axis_maximum;
        logic [CFG_W-1:0] axis_center;
        logic [CFG_W-1:0] dead_band;
        logic [CFG_W-1:0] full_scale_span;
    } t_regs;

    typedef struct packed {
        logic [CFG_W-1:0] den;
        logic [CFG_W-1:0] span;
        logic             span_neg;
        logic [CFG_W-1:0] rest_raw;
    } t_dcfg;

    typedef struct packed {
        logic neg;
        logic in_dz;
    } t_side;

    // Number of quotient bits per lane, rounded up to a whole number of stages.
    function automatic int div_bits(input int frac);
        int n;
        n = (frac + 2 > 13) ? frac + 2 : 13;
        return ((n + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    endfunction

endpackage

@@ sv/sadr_stream_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
interface sadr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/stick_axis_deadzone_rescale.sv @@
// Top level of the stick axis deadzone rescaler.
// One item per cycle unless o_out stalls; a divider stage resolves two quotient bits per lane.
// Each stage stalls only when full and its successor is blocked, so bubbles close up.
// Reset clears all valid bits and loads the default axis registers; configuration is always ready.
module stick_axis_deadzone_rescale #(
    parameter int FRACTION_BITS = sadr_pkg::FRACTION_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sadr_stream_if.sink    i_in,
    sadr_stream_if.sink    i_cfg,
    sadr_stream_if.source  o_out
);
    import sadr_pkg::*;

    localparam int K     = FRACTION_BITS + 1;
    localparam int NSTEP = div_bits(FRACTION_BITS);
    localparam int NST   = NSTEP / DIV_STEPS;

    t_regs                    r_regs;
    t_dcfg                    r_dcfg, n_dcfg;
    logic [CFG_W:0]           v_dd;

    logic                     f_valid;
    t_side                    f_side;
    logic [CFG_W-1:0]         f_num;
    logic [2*CFG_W-1:0]       f_prod;
    logic [CFG_W+K-1:0]       v_xq;
    logic [2*CFG_W:0]         v_x2;

    logic                     s_valid [NST+1];
    logic                     s_ready [NST+1];
    t_side                    s_side  [NST+1];
    logic [1:0][CFG_W-1:0]    s_rem   [NST+1];
    logic [1:0][NSTEP-1:0]    s_dvd   [NST+1];
    logic [1:0][NSTEP-1:0]    s_quo   [NST+1];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.axis_maximum    <= AXIS_MAXIMUM_RST;
            r_regs.axis_center     <= AXIS_CENTER_RST;
            r_regs.dead_band       <= DEAD_BAND_RST;
            r_regs.full_scale_span <= FULL_SCALE_SPAN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_AXIS_MAXIMUM:    r_regs.axis_maximum    <= i_cfg.data.value;
                CFG_AXIS_CENTER:     r_regs.axis_center     <= i_cfg.data.value;
                CFG_DEAD_BAND:       r_regs.dead_band       <= i_cfg.data.value;
                CFG_FULL_SCALE_SPAN: r_regs.full_scale_span <= i_cfg.data.value;
            endcase
        end
    end

    always_comb begin
        v_dd = {1'b0, r_regs.full_scale_span} - {1'b0, r_regs.dead_band};
        n_dcfg.den      = (r_regs.full_scale_span <= r_regs.dead_band) ? CFG_W'(1)
                                                                       : v_dd[CFG_W-1:0];
        n_dcfg.span     = r_regs.axis_maximum - r_regs.axis_center;
        n_dcfg.span_neg = (r_regs.axis_maximum < r_regs.axis_center);
        n_dcfg.rest_raw = (r_regs.axis_center > r_regs.axis_maximum) ? r_regs.axis_maximum
                                                                     : r_regs.axis_center;
    end

    always_ff @(posedge i_clk) begin
        r_dcfg <= n_dcfg;
    end

    sadr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_regs       (r_regs),
        .i_dcfg       (r_dcfg),
        .i_ready_next (s_ready[0]),
        .o_valid      (f_valid),
        .o_side       (f_side),
        .o_num        (f_num),
        .o_prod       (f_prod)
    );

    always_comb begin
        v_xq = {f_num, {K{1'b0}}};
        v_x2 = {f_prod, 1'b0};
        s_valid[0]         = f_valid;
        s_side[0]          = f_side;
        s_rem[0][LANE_Q]   = CFG_W'(v_xq >> NSTEP);
        s_dvd[0][LANE_Q]   = v_xq[NSTEP-1:0];
        s_rem[0][LANE_R]   = CFG_W'(v_x2 >> NSTEP);
        s_dvd[0][LANE_R]   = v_x2[NSTEP-1:0];
        s_quo[0]           = '0;
    end

    for (genvar k = 0; k < NST; k++) begin : g_div
        sadr_div_stage #(
            .NSTEP (NSTEP)
        ) u_stage (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (s_valid[k]),
            .i_side       (s_side[k]),
            .i_rem        (s_rem[k]),
            .i_dvd        (s_dvd[k]),
            .i_quo        (s_quo[k]),
            .i_den        (r_dcfg.den),
            .i_ready_next (s_ready[k+1]),
            .o_ready      (s_ready[k]),
            .o_valid      (s_valid[k+1]),
            .o_side       (s_side[k+1]),
            .o_rem        (s_rem[k+1]),
            .o_dvd        (s_dvd[k+1]),
            .o_quo        (s_quo[k+1])
        );
    end

    sadr_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .NSTEP         (NSTEP)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[NST]),
        .i_side  (s_side[NST]),
        .i_quo   (s_quo[NST]),
        .i_regs  (r_regs),
        .i_dcfg  (r_dcfg),
        .o_ready (s_ready[NST]),
        .o_out   (o_out)
    );

endmodule

@@ sv/sadr_front.sv @@
// Front pipeline: clamp, centre, deadzone test, ratio operands and raw product.
module sadr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sadr_stream_if.sink                       i_in,
    input  sadr_pkg::t_regs                   i_regs,
    input  sadr_pkg::t_dcfg                   i_dcfg,
    input  logic                              i_ready_next,
    output logic                              o_valid,
    output sadr_pkg::t_side                   o_side,
    output logic [sadr_pkg::CFG_W-1:0]        o_num,
    output logic [2*sadr_pkg::CFG_W-1:0]      o_prod
);
    import sadr_pkg::*;

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic                      en1, en2, en3, en4;
    logic                      r_neg1, r_neg2;
    logic signed [CFG_W:0]     r_cent1, n_cent1;
    logic                      r_inside2, n_inside2;
    logic signed [CFG_W:0]     r_exc2, n_exc2;
    t_side                     r_side3, r_side4;
    logic [CFG_W-1:0]          r_num3, n_num3, r_num4;
    logic [CFG_W-1:0]          r_a3, n_a3, r_b3, n_b3;
    logic [2*CFG_W-1:0]        r_prod4;
    logic [CFG_W-1:0]          v_smp, v_mag;

    assign en4 = !r_v4 || i_ready_next;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    always_comb begin
        if (i_in.data.raw_sample > {{(IN_W-CFG_W){1'b0}}, i_regs.axis_maximum}) begin
            v_smp = i_regs.axis_maximum;
        end else begin
            v_smp = i_in.data.raw_sample[CFG_W-1:0];
        end
        n_cent1 = $signed({1'b0, v_smp}) - $signed({1'b0, i_regs.axis_center});

        v_mag = r_neg1 ? CFG_W'(-r_cent1) : CFG_W'(r_cent1);
        n_inside2 = (v_mag <= i_regs.dead_band);
        n_exc2 = $signed({1'b0, v_mag}) - $signed({1'b0, i_regs.dead_band});

        if (r_exc2 > $signed({1'b0, i_dcfg.den})) begin
            n_num3 = i_dcfg.den;
        end else begin
            n_num3 = r_exc2[CFG_W-1:0];
        end
        n_a3 = r_neg2 ? i_regs.axis_center : i_dcfg.span;
        n_b3 = r_neg2 ? (i_dcfg.den - n_num3) : n_num3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in.valid) begin
            r_cent1 <= n_cent1;
            r_neg1  <= n_cent1[CFG_W];
        end
        if (en2 && r_v1) begin
            r_neg2    <= r_neg1;
            r_inside2 <= n_inside2;
            r_exc2    <= n_exc2;
        end
        if (en3 && r_v2) begin
            r_side3.neg   <= r_neg2;
            r_side3.in_dz <= r_inside2;
            r_num3        <= n_num3;
            r_a3          <= n_a3;
            r_b3          <= n_b3;
        end
        if (en4 && r_v3) begin
            r_side4 <= r_side3;
            r_num4  <= r_num3;
            r_prod4 <= {{CFG_W{1'b0}}, r_a3} * {{CFG_W{1'b0}}, r_b3};
        end
    end

    assign o_valid = r_v4;
    assign o_side  = r_side4;
    assign o_num   = r_num4;
    assign o_prod  = r_prod4;

endmodule

@@ sv/sadr_div_stage.sv @@
// One stage of the two-lane restoring divider, a fixed number of quotient bits per stage.
module sadr_div_stage #(
    parameter int NSTEP = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  sadr_pkg::t_side                        i_side,
    input  logic [1:0][sadr_pkg::CFG_W-1:0]        i_rem,
    input  logic [1:0][NSTEP-1:0]                  i_dvd,
    input  logic [1:0][NSTEP-1:0]                  i_quo,
    input  logic [sadr_pkg::CFG_W-1:0]             i_den,
    input  logic                                   i_ready_next,
    output logic                                   o_ready,
    output logic                                   o_valid,
    output sadr_pkg::t_side                        o_side,
    output logic [1:0][sadr_pkg::CFG_W-1:0]        o_rem,
    output logic [1:0][NSTEP-1:0]                  o_dvd,
    output logic [1:0][NSTEP-1:0]                  o_quo
);
    import sadr_pkg::*;

    logic                         r_valid;
    t_side                        r_side;
    logic [1:0][CFG_W-1:0]        r_rem, n_rem;
    logic [1:0][NSTEP-1:0]        r_dvd, n_dvd, r_quo, n_quo;
    logic [CFG_W:0]               v_t;
    logic                         v_bit;

    assign o_ready = !r_valid || i_ready_next;

    always_comb begin
        n_rem = i_rem;
        n_dvd = i_dvd;
        n_quo = i_quo;
        v_t   = '0;
        v_bit = 1'b0;
        for (int l = 0; l < 2; l++) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                v_t = {n_rem[l], n_dvd[l][NSTEP-1]};
                if (v_t >= {1'b0, i_den}) begin
                    v_bit    = 1'b1;
                    n_rem[l] = CFG_W'(v_t - {1'b0, i_den});
                end else begin
                    v_bit    = 1'b0;
                    n_rem[l] = v_t[CFG_W-1:0];
                end
                n_dvd[l] = {n_dvd[l][NSTEP-2:0], 1'b0};
                n_quo[l] = {n_quo[l][NSTEP-2:0], v_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_dvd  <= n_dvd;
            r_quo  <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;
    assign o_quo   = r_quo;

endmodule

@@ sv/sadr_back.sv @@
// Output stage: rounds both quotients, applies sign and clamps, and holds the result item.
module sadr_back #(
    parameter int FRACTION_BITS = sadr_pkg::FRACTION_BITS_DEF,
    parameter int NSTEP         = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sadr_pkg::t_side               i_side,
    input  logic [1:0][NSTEP-1:0]         i_quo,
    input  sadr_pkg::t_regs               i_regs,
    input  sadr_pkg::t_dcfg               i_dcfg,
    output logic                          o_ready,
    sadr_stream_if.source                 o_out
);
    import sadr_pkg::*;

    logic              r_valid;
    logic              r_neg;
    t_out              r_out, n_out;
    logic [NSTEP:0]    v_qinc, v_rinc;
    logic [NORM_W-1:0] v_q16;
    logic [RAW_W-1:0]  v_rr;
    logic [RAW_W:0]    v_sum;

    assign o_ready = !r_valid || o_out.ready;

    always_comb begin
        v_qinc = {1'b0, i_quo[LANE_Q]} + (NSTEP+1)'(1);
        v_rinc = {1'b0, i_quo[LANE_R]} + (NSTEP+1)'(1);
        v_q16  = NORM_W'(v_qinc[NSTEP:1]);
        v_rr   = RAW_W'(v_rinc[NSTEP:1]);
        v_sum  = {1'b0, i_regs.axis_center} + {1'b0, v_rr};
        n_out.inside_dead_band = i_side.in_dz;
        if (i_side.in_dz) begin
            n_out.normalized_q14 = '0;
            n_out.rescaled_raw   = i_dcfg.rest_raw;
        end else if (i_side.neg) begin
            n_out.normalized_q14 = $signed(-v_q16);
            n_out.rescaled_raw   = (v_rr > i_regs.axis_center) ? i_regs.axis_center : v_rr;
        end else begin
            n_out.normalized_q14 = $signed(v_q16);
            if (i_dcfg.span_neg) begin
                n_out.rescaled_raw = i_regs.axis_maximum;
            end else if (v_sum > {1'b0, i_regs.axis_maximum}) begin
                n_out.rescaled_raw = i_regs.axis_maximum;
            end else begin
                n_out.rescaled_raw = v_sum[RAW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out <= n_out;
            r_neg <= i_side.neg;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_out;

    a_dead_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.inside_dead_band |-> r_out.normalized_q14 == '0)
        else $error("deadzone item with non-zero deflection");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_valid)
        else $error("output valid straight after reset");

    a_positive_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FRACTION_BITS < 15) && r_valid && !r_out.inside_dead_band && !r_neg
        |-> !r_out.normalized_q14[NORM_W-1])
        else $error("positive deflection came out negative");

endmodule

@@ verif/tb_stick_axis_deadzone_rescale.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stick axis deadzone rescaler with a built-in predictor.
module tb_stick_axis_deadzone_rescale;
    import sadr_pkg::*;

    localparam int FRAC        = FRACTION_BITS_DEF;
    localparam int LAT         = 5 + div_bits(FRAC) / 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 110;

    class axis_scoreboard;
        longint maximum;
        longint center;
        longint dead_width;
        longint full_span;
        t_out   expected_q[$];
        int     errors;

        function new();
            maximum    = longint'(AXIS_MAXIMUM_RST);
            center     = longint'(AXIS_CENTER_RST);
            dead_width = longint'(DEAD_BAND_RST);
            full_span  = longint'(FULL_SCALE_SPAN_RST);
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_AXIS_MAXIMUM:    maximum    = longint'(v);
                CFG_AXIS_CENTER:     center     = longint'(v);
                CFG_DEAD_BAND:       dead_width = longint'(v);
                CFG_FULL_SCALE_SPAN: full_span  = longint'(v);
                default: ;
            endcase
        endfunction

        function longint round_half_up(longint num, longint den);
            return (2 * num + den) / (2 * den);
        endfunction

        function t_out rescale(logic [IN_W-1:0] raw);
            longint smp, centred, mag, num, den, q, raw_o, span, prod, off;
            bit     neg;
            t_out   res;
            smp = longint'(raw);
            if (smp > maximum) smp = maximum;
            centred = smp - center;
            neg = centred < 0;
            mag = neg ? -centred : centred;
            if (mag <= dead_width) begin
                raw_o = center;
                if (raw_o > maximum) raw_o = maximum;
                res.normalized_q14   = '0;
                res.rescaled_raw     = raw_o[RAW_W-1:0];
                res.inside_dead_band = 1'b1;
                return res;
            end
            den = full_span - dead_width;
            num = mag - dead_width;
            if (den <= 0) begin
                num = 1;
                den = 1;
            end else if (num > den) begin
                num = den;
            end
            q = round_half_up(num * (64'sd1 << FRAC), den);
            if (neg) begin
                q = -q;
                raw_o = round_half_up(center * (den - num), den);
                if (raw_o < 0) raw_o = 0;
                if (raw_o > center) raw_o = center;
            end else begin
                span = maximum - center;
                prod = span * num;
                off = (prod < 0) ? -round_half_up(-prod, den) : round_half_up(prod, den);
                raw_o = center + off;
                if (raw_o < center) raw_o = center;
                if (raw_o > maximum) raw_o = maximum;
            end
            res.normalized_q14   = q[NORM_W-1:0];
            res.rescaled_raw     = raw_o[RAW_W-1:0];
            res.inside_dead_band = 1'b0;
            return res;
        endfunction

        function void note_sample(logic [IN_W-1:0] raw);
            expected_q.push_back(rescale(raw));
        endfunction

        function void check_result(t_out got);
            t_out exp_item;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item: normalized %0d raw %0d inside %0b", $time,
                         got.normalized_q14, got.rescaled_raw, got.inside_dead_band);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.normalized_q14 !== exp_item.normalized_q14) begin
                $display("%0t: normalized_q14 expected %0d actual %0d", $time,
                         exp_item.normalized_q14, got.normalized_q14);
                errors++;
            end
            if (got.rescaled_raw !== exp_item.rescaled_raw) begin
                $display("%0t: rescaled_raw expected %0d actual %0d", $time,
                         exp_item.rescaled_raw, got.rescaled_raw);
                errors++;
            end
            if (got.inside_dead_band !== exp_item.inside_dead_band) begin
                $display("%0t: inside_dead_band expected %0b actual %0b", $time,
                         exp_item.inside_dead_band, got.inside_dead_band);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   cycles;

    axis_scoreboard sb;

    sadr_stream_if #(.T(t_in))     in_if ();
    sadr_stream_if #(.T(t_cfg_wr)) cfg_if ();
    sadr_stream_if #(.T(t_out))    out_if ();

    stick_axis_deadzone_rescale #(
        .FRACTION_BITS(FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.set_reg(cfg_if.data.index, cfg_if.data.value);
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_sample(in_if.data.raw_sample);
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.data);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        @(negedge i_clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= idx;
        cfg_if.data.value <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_setting(t_regs s);
        write_reg(CFG_AXIS_MAXIMUM, s.axis_maximum);
        write_reg(CFG_AXIS_CENTER, s.axis_center);
        write_reg(CFG_DEAD_BAND, s.dead_band);
        write_reg(CFG_FULL_SCALE_SPAN, s.full_scale_span);
    endtask

    task automatic send_sample(int v);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 10) ? 1 : 0;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid           <= 1'b1;
        in_if.data.raw_sample <= v[IN_W-1:0];
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (LAT) @(negedge i_clk);
    endtask

    function automatic int pick_sample();
        int c, d, f, w, sel, v;
        c = int'(sb.center);
        d = int'(sb.dead_width);
        f = int'(sb.full_span);
        w = ((f > d) ? f : d) + 40;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            v = c - w + int'($urandom_range(0, 2 * w));
        end else if (sel < 60) begin
            case ($urandom_range(0, 5))
                0: v = c + d;
                1: v = c + d + 1;
                2: v = c - d;
                3: v = c - d - 1;
                4: v = c + f;
                default: v = c - f;
            endcase
            v = v + int'($urandom_range(0, 2)) - 1;
        end else if (sel < 85) begin
            v = $urandom_range(0, 4095);
        end else begin
            v = $urandom_range(0, 65535);
        end
        return v;
    endfunction

    function automatic t_regs setting_for(int phase);
        t_regs s;
        case (phase)
            0: s = '{12'd4095, 12'd2048, 12'd160, 12'd1600};
            1: s = '{12'd4095, 12'd0, 12'd0, 12'd1};
            2: s = '{12'd4095, 12'd4095, 12'd4095, 12'd4095};
            3: s = '{12'd1, 12'd1, 12'd0, 12'd4095};
            4: s = '{12'd1000, 12'd3000, 12'd100, 12'd500};
            5: s = '{12'd4095, 12'd2048, 12'd600, 12'd300};
            6: s = '{12'd2000, 12'd1000, 12'd200, 12'd200};
            7: s = '{12'd4095, 12'd2048, 12'd0, 12'd4095};
            default: begin
                s.axis_maximum    = CFG_W'($urandom_range(1, 4095));
                s.axis_center     = CFG_W'($urandom_range(0, 4095));
                s.dead_band       = CFG_W'($urandom_range(0, 800));
                s.full_scale_span = CFG_W'($urandom_range(1, 4095));
            end
        endcase
        return s;
    endfunction

    initial begin
        int directed [$];
        sb = new();
        steady = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{0, 65535, 4095, 4096, 2048, 2208, 2209, 1888, 1887, 3648, 448, 3649,
                     447, 3647, 449, 32768, 21845, 43690, 2049, 2047, 1, 4094};
        foreach (directed[k]) send_sample(directed[k]);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            steady = (phase == 3);
            load_setting(setting_for(phase));
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample());
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
